// ===== hw/rtl/spbp_pkg.sv =====
`default_nettype none

package spbp_pkg;

    // Header constants
    localparam logic [7:0] MAGIC_FIRST   = 8'h38;
    localparam logic [7:0] MAGIC_SECOND  = 8'h47;
    localparam logic [7:0] PROC_SETUP    = 8'h01;
    localparam logic [7:0] KIND_REQUEST  = 8'h00;
    localparam logic [7:0] KIND_RESPONSE = 8'h01;
    localparam logic [7:0] KIND_FAILURE  = 8'h02;

    // End status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_HDR_ERR   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef enum logic [3:0] {
        PH_H0        = 4'd0,
        PH_H1        = 4'd1,
        PH_H2        = 4'd2,
        PH_H3        = 4'd3,
        PH_REQ_TID   = 4'd4,
        PH_REQ_UNIT  = 4'd5,
        PH_REQ_NLEN  = 4'd6,
        PH_REQ_NAME  = 4'd7,
        PH_REQ_NCELL = 4'd8,
        PH_REQ_CELL  = 4'd9,
        PH_RSP_TID   = 4'd10,
        PH_RSP_NLEN  = 4'd11,
        PH_RSP_NAME  = 4'd12,
        PH_RSP_NCELL = 4'd13,
        PH_RSP_CELL  = 4'd14,
        PH_FAIL_BODY = 4'd15
    } phase_t;

    typedef enum logic [2:0] {
        REC_REQ_HDR  = 3'd0,
        REC_NAME     = 3'd1,
        REC_SERVED   = 3'd2,
        REC_RSP_HDR  = 3'd3,
        REC_ACTIVE   = 3'd4,
        REC_FAILURE  = 3'd5,
        REC_END      = 3'd6
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t   kind;
        logic [15:0] transaction_id;
        logic [63:0] node_id;
        logic [31:0] arfcn;
        logic [7:0]  scs;
        logic [15:0] pci;
        logic [15:0] tac;
        logic [7:0]  cause_type;
        logic [7:0]  cause_value;
        logic [7:0]  name_char;
        logic [1:0]  status;
        logic        last;
    } rec_t;

    // Records produced by one byte: a parse record, then an end record
    typedef struct packed {
        logic a_vld;
        rec_t a;
        logic b_vld;
        rec_t b;
    } recs_t;

endpackage

`default_nettype wire

// ===== hw/rtl/setup_pdu_byte_parser.sv =====
// Setup PDU byte parser.
// Input channel (s_valid/s_ready): one PDU byte per item, s_end_of_pdu on the
// last byte of the buffer. Result channel (m_valid/m_ready): one record per
// item, m_rec_kind selects which fields carry data, the others read 0.
// cfg_wr_en/cfg_wr_data set the expected PDU type; write it only while idle.
// Records of an accepted byte are registered in the queue and offered from
// there. Throughput: one byte per cycle while s_ready is high; each byte
// yields zero, one or two records (parse record and end status), and the
// result side drains one per cycle while m_ready is high.
// Records wait in a 4-entry queue; s_ready is high while at least two
// entries are free, so a stalled receiver holds off the sender after at
// most four records and nothing is dropped.
// Reset (aresetn low, synchronous): queue empty, parser at the first header
// byte, expected PDU type 0 (request).
`default_nettype none

module setup_pdu_byte_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_value,
    input  wire logic        s_end_of_pdu,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_rec_kind,
    output logic [15:0]      m_transaction_id,
    output logic [63:0]      m_node_id,
    output logic [31:0]      m_arfcn,
    output logic [7:0]       m_scs,
    output logic [15:0]      m_pci,
    output logic [15:0]      m_tac,
    output logic [7:0]       m_cause_type,
    output logic [7:0]       m_cause_value,
    output logic [7:0]       m_name_char,
    output logic [1:0]       m_status,
    output logic             m_last
);
    import spbp_pkg::*;

    logic        take;
    logic        pop;
    recs_t       recs;
    rec_t        q_reg [4];
    logic [1:0]  wptr_reg, wptr_next;
    logic [1:0]  rptr_reg, rptr_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  wptr_b;
    logic [1:0]  n_push;
    rec_t        head;

    assign take = s_valid & s_ready;
    assign pop  = m_valid & m_ready;

    spbp_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .take        (take),
        .byte_value  (s_byte_value),
        .end_of_pdu  (s_end_of_pdu),
        .recs        (recs)
    );

    // Queue pointers and fill level
    always_comb begin
        n_push    = {1'b0, recs.a_vld} + {1'b0, recs.b_vld};
        wptr_b    = wptr_reg + {1'b0, recs.a_vld};
        wptr_next = wptr_reg + n_push;
        rptr_next = rptr_reg + {1'b0, pop};
        cnt_next  = cnt_reg + {1'b0, n_push} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Record storage
    always_ff @(posedge aclk) begin
        if (recs.a_vld) q_reg[wptr_reg] <= recs.a;
        if (recs.b_vld) q_reg[wptr_b] <= recs.b;
    end

    assign s_ready = (cnt_reg <= 3'd2);
    assign m_valid = (cnt_reg != 3'd0);
    assign head    = q_reg[rptr_reg];

    assign m_rec_kind       = head.kind;
    assign m_transaction_id = head.transaction_id;
    assign m_node_id        = head.node_id;
    assign m_arfcn          = head.arfcn;
    assign m_scs            = head.scs;
    assign m_pci            = head.pci;
    assign m_tac            = head.tac;
    assign m_cause_type     = head.cause_type;
    assign m_cause_value    = head.cause_value;
    assign m_name_char      = head.name_char;
    assign m_status         = head.status;
    assign m_last           = head.last;

    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 3'd4)
        else $error("record queue overflow");

    // Second record of a byte is always the end status
    assert property (@(posedge aclk) disable iff (!aresetn)
        recs.b_vld |-> (recs.b.kind == REC_END) && recs.b.last)
        else $error("second record is not an end status");

    // An accepted end byte leaves a record waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_end_of_pdu) |=> m_valid)
        else $error("end byte produced no record");

endmodule

`default_nettype wire

// ===== hw/rtl/spbp_parse.sv =====
`default_nettype none

module spbp_parse (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    input  wire logic        take,
    input  wire logic [7:0]  byte_value,
    input  wire logic        end_of_pdu,
    output spbp_pkg::recs_t  recs
);
    import spbp_pkg::*;

    logic [1:0]  pdu_kind_reg;
    phase_t      phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [7:0]  name_left_reg, name_left_next;
    logic [7:0]  cells_left_reg, cells_left_next;
    logic [15:0] tid_reg, tid_next;
    logic [63:0] ident_reg, ident_next;
    logic [31:0] arfcn_reg, arfcn_next;
    logic [7:0]  scs_reg, scs_next;
    logic [15:0] pci_reg, pci_next;
    logic [7:0]  ctype_reg, ctype_next;
    logic        err_reg, err_next;
    logic        done_reg, done_next;

    logic [63:0] acc_shift;
    logic [4:0]  cnt_inc;
    logic [7:0]  cells_dec;
    logic [7:0]  name_dec;
    rec_t        rec_a;
    logic        rec_a_vld;
    rec_t        rec_b;

    assign acc_shift = {acc_reg[55:0], byte_value};
    assign cnt_inc   = cnt_reg + 5'd1;
    assign cells_dec = cells_left_reg - 8'd1;
    assign name_dec  = name_left_reg - 8'd1;

    // Parse step for one byte
    always_comb begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        name_left_next  = name_left_reg;
        cells_left_next = cells_left_reg;
        tid_next        = tid_reg;
        ident_next      = ident_reg;
        arfcn_next      = arfcn_reg;
        scs_next        = scs_reg;
        pci_next        = pci_reg;
        ctype_next      = ctype_reg;
        err_next        = err_reg;
        done_next       = done_reg;
        rec_a           = '0;
        rec_a_vld       = 1'b0;
        rec_b           = '0;

        if (!err_reg && !done_reg) begin
            case (phase_reg)
                PH_H0: begin
                    if (byte_value == MAGIC_FIRST) phase_next = PH_H1;
                    else err_next = 1'b1;
                end
                PH_H1: begin
                    if (byte_value == MAGIC_SECOND) phase_next = PH_H2;
                    else err_next = 1'b1;
                end
                PH_H2: begin
                    if (byte_value == PROC_SETUP) phase_next = PH_H3;
                    else err_next = 1'b1;
                end
                PH_H3: begin
                    cnt_next = '0;
                    acc_next = '0;
                    if (byte_value != {6'd0, pdu_kind_reg}) err_next = 1'b1;
                    else if (byte_value == KIND_REQUEST) phase_next = PH_REQ_TID;
                    else if (byte_value == KIND_RESPONSE) phase_next = PH_RSP_TID;
                    else if (byte_value == KIND_FAILURE) phase_next = PH_FAIL_BODY;
                    else err_next = 1'b1;
                end
                PH_REQ_TID, PH_RSP_TID: begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    if (cnt_inc == 5'd2) begin
                        tid_next = acc_shift[15:0];
                        cnt_next = '0;
                        acc_next = '0;
                        if (phase_reg == PH_RSP_TID) begin
                            rec_a_vld            = 1'b1;
                            rec_a.kind           = REC_RSP_HDR;
                            rec_a.transaction_id = acc_shift[15:0];
                            phase_next           = PH_RSP_NLEN;
                        end else begin
                            phase_next = PH_REQ_UNIT;
                        end
                    end
                end
                PH_REQ_UNIT: begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    if (cnt_inc == 5'd8) begin
                        rec_a_vld            = 1'b1;
                        rec_a.kind           = REC_REQ_HDR;
                        rec_a.transaction_id = tid_reg;
                        rec_a.node_id        = acc_shift;
                        cnt_next             = '0;
                        acc_next             = '0;
                        phase_next           = PH_REQ_NLEN;
                    end
                end
                PH_REQ_NLEN, PH_RSP_NLEN: begin
                    name_left_next = byte_value;
                    if (phase_reg == PH_REQ_NLEN)
                        phase_next = (byte_value != 8'd0) ? PH_REQ_NAME : PH_REQ_NCELL;
                    else
                        phase_next = (byte_value != 8'd0) ? PH_RSP_NAME : PH_RSP_NCELL;
                end
                PH_REQ_NAME, PH_RSP_NAME: begin
                    rec_a_vld       = 1'b1;
                    rec_a.kind      = REC_NAME;
                    rec_a.name_char = byte_value;
                    name_left_next  = name_dec;
                    if (name_dec == 8'd0)
                        phase_next = (phase_reg == PH_REQ_NAME) ? PH_REQ_NCELL : PH_RSP_NCELL;
                end
                PH_REQ_NCELL, PH_RSP_NCELL: begin
                    cells_left_next = byte_value;
                    cnt_next        = '0;
                    acc_next        = '0;
                    if (byte_value == 8'd0) done_next = 1'b1;
                    else phase_next = (phase_reg == PH_REQ_NCELL) ? PH_REQ_CELL : PH_RSP_CELL;
                end
                PH_REQ_CELL: begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    case (cnt_inc)
                        5'd8: begin
                            ident_next = acc_shift;
                            acc_next   = '0;
                        end
                        5'd12: begin
                            arfcn_next = acc_shift[31:0];
                            acc_next   = '0;
                        end
                        5'd13: begin
                            scs_next = byte_value;
                            acc_next = '0;
                        end
                        5'd15: begin
                            pci_next = acc_shift[15:0];
                            acc_next = '0;
                        end
                        5'd17: begin
                            rec_a_vld       = 1'b1;
                            rec_a.kind      = REC_SERVED;
                            rec_a.node_id   = ident_reg;
                            rec_a.arfcn     = arfcn_reg;
                            rec_a.scs       = scs_reg;
                            rec_a.pci       = pci_reg;
                            rec_a.tac       = acc_shift[15:0];
                            cnt_next        = '0;
                            acc_next        = '0;
                            cells_left_next = cells_dec;
                            if (cells_dec == 8'd0) done_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                PH_RSP_CELL: begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    if (cnt_inc == 5'd8) begin
                        rec_a_vld       = 1'b1;
                        rec_a.kind      = REC_ACTIVE;
                        rec_a.node_id   = acc_shift;
                        cnt_next        = '0;
                        acc_next        = '0;
                        cells_left_next = cells_dec;
                        if (cells_dec == 8'd0) done_next = 1'b1;
                    end
                end
                PH_FAIL_BODY: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc <= 5'd2) begin
                        tid_next = {tid_reg[7:0], byte_value};
                    end else if (cnt_inc == 5'd3) begin
                        ctype_next = byte_value;
                    end else begin
                        rec_a_vld            = 1'b1;
                        rec_a.kind           = REC_FAILURE;
                        rec_a.transaction_id = tid_reg;
                        rec_a.cause_type     = ctype_reg;
                        rec_a.cause_value    = byte_value;
                        done_next            = 1'b1;
                    end
                end
                default: begin
                    err_next = err_reg;
                end
            endcase
        end

        // End byte: status record, then back to the first header byte
        if (end_of_pdu) begin
            rec_b.kind      = REC_END;
            rec_b.status    = err_next ? ST_HDR_ERR : (done_next ? ST_OK : ST_TRUNCATED);
            rec_b.last      = 1'b1;
            phase_next      = PH_H0;
            cnt_next        = '0;
            acc_next        = '0;
            name_left_next  = '0;
            cells_left_next = '0;
            tid_next        = '0;
            ident_next      = '0;
            arfcn_next      = '0;
            scs_next        = '0;
            pci_next        = '0;
            ctype_next      = '0;
            err_next        = 1'b0;
            done_next       = 1'b0;
        end else begin
            rec_a.last = 1'b1;
        end
    end

    assign recs.a_vld = take & rec_a_vld;
    assign recs.a     = rec_a;
    assign recs.b_vld = take & end_of_pdu;
    assign recs.b     = rec_b;

    // Expected PDU type
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pdu_kind_reg <= '0;
        end else if (cfg_wr_en) begin
            pdu_kind_reg <= cfg_wr_data;
        end
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_H0;
            cnt_reg        <= '0;
            acc_reg        <= '0;
            name_left_reg  <= '0;
            cells_left_reg <= '0;
            tid_reg        <= '0;
            ident_reg      <= '0;
            arfcn_reg      <= '0;
            scs_reg        <= '0;
            pci_reg        <= '0;
            ctype_reg      <= '0;
            err_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end else if (take) begin
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            acc_reg        <= acc_next;
            name_left_reg  <= name_left_next;
            cells_left_reg <= cells_left_next;
            tid_reg        <= tid_next;
            ident_reg      <= ident_next;
            arfcn_reg      <= arfcn_next;
            scs_reg        <= scs_next;
            pci_reg        <= pci_next;
            ctype_reg      <= ctype_next;
            err_reg        <= err_next;
            done_reg       <= done_next;
        end
    end

endmodule

`default_nettype wire
